/* rtl/core/bre_pkg.sv */
// Shared constants and types of the bit run-length encoder.
package bre_pkg;

   localparam int FRAME_BYTES   = 32;
   localparam int BITS_PER_BYTE = 8;
   localparam int MAX_RESULTS   = 18;
   localparam int QUEUE_DEPTH   = 2;

   localparam int IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int RES_W  = $clog2(MAX_RESULTS + 1);
   localparam int BCNT_W = $clog2(BITS_PER_BYTE + 1);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       frame_end;
      logic [7:0] data_byte;
   } entry_type;

   typedef struct packed {
      logic [3:0] symbol_nibble;
      logic       is_run_bit;
      logic       last;
      logic       frame_done;
   } result_type;

endpackage

/* rtl/core/bre_if.sv */
// Valid/ready channel interfaces for the request and response sides.
interface bre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface bre_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] symbol_nibble;
   logic       is_run_bit;
   logic       last;
   logic       frame_done;

   modport source (output valid, output symbol_nibble, output is_run_bit, output last,
                   output frame_done, input ready);
   modport sink (input valid, input symbol_nibble, input is_run_bit, input last,
                 input frame_done, output ready);
endinterface

/* rtl/core/bre_front.sv */
// Front end: accepts bytes and tags the last byte of each frame.
module bre_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                q_full,
   output logic                q_push,
   output bre_pkg::entry_type  q_entry
);

   logic [bre_pkg::IDX_W-1:0] idx_ff;
   logic [bre_pkg::IDX_W-1:0] idx_in;
   logic                      frame_end;

   assign in_ready  = !q_full;
   assign q_push    = in_valid && !q_full;
   assign frame_end = (idx_ff == bre_pkg::IDX_W'(bre_pkg::FRAME_BYTES - 1));

   always_comb begin
      q_entry.frame_end = frame_end;
      q_entry.data_byte = in_byte;
      idx_in            = idx_ff;
      if (q_push) begin
         idx_in = frame_end ? '0 : bre_pkg::IDX_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/core/bre_queue.sv */
// Small first-in first-out queue between the front and back ends.
module bre_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bre_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output bre_pkg::entry_type  head
);

   bre_pkg::entry_type              slot_ff [bre_pkg::QUEUE_DEPTH];
   logic [bre_pkg::PTR_W-1:0]       wr_ptr_ff;
   logic [bre_pkg::PTR_W-1:0]       rd_ptr_ff;
   logic [bre_pkg::QCNT_W-1:0]      count_ff;
   logic                            do_push;
   logic                            do_pop;

   assign full      = (count_ff == bre_pkg::QCNT_W'(bre_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bre_pkg::PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= bre_pkg::PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= bre_pkg::QCNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= bre_pkg::QCNT_W'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/bre_back.sv */
// Back end: walks the bits of each byte, counts runs and emits the nibbles.
module bre_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bre_pkg::entry_type  q_head,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output bre_pkg::result_type out_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BITS  = 7'b0000010,
      ST_HUND  = 7'b0000100,
      ST_TENS  = 7'b0001000,
      ST_UNITS = 7'b0010000,
      ST_RBIT  = 7'b0100000,
      ST_END   = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       fe_ff, fe_in;
   logic [bre_pkg::BCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                       run_bit_ff, run_bit_in;
   logic [3:0]                 hund_ff, hund_in;
   logic [3:0]                 tens_ff, tens_in;
   logic [3:0]                 units_ff, units_in;
   logic [3:0]                 em_hund_ff, em_hund_in;
   logic [3:0]                 em_tens_ff, em_tens_in;
   logic [3:0]                 em_units_ff, em_units_in;
   logic                       em_bit_ff, em_bit_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [3:0]                 pend_sym_ff, pend_sym_in;
   logic                       pend_rbit_ff, pend_rbit_in;
   logic [bre_pkg::RES_W-1:0]  byte_res_ff, byte_res_in;
   logic                       out_valid_ff, out_valid_in;
   bre_pkg::result_type        out_ff, out_in;

   logic                       out_free;
   logic                       count_nz;
   logic                       room;
   logic [3:0]                 cur_sym;
   logic                       cur_rbit;
   logic                       bit_now;
   logic                       push;
   bre_pkg::result_type        push_data;
   state_type                  first_digit;

   assign out_free  = !out_valid_ff || out_ready;
   assign count_nz  = (hund_ff != '0) || (tens_ff != '0) || (units_ff != '0);
   assign room      = (byte_res_ff < bre_pkg::RES_W'(bre_pkg::MAX_RESULTS));
   assign bit_now   = byte_ff[7];
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // First digit of the run being closed, with leading zeros suppressed.
   always_comb begin
      if (hund_ff != '0) begin
         first_digit = ST_HUND;
      end else if (tens_ff != '0) begin
         first_digit = ST_TENS;
      end else begin
         first_digit = ST_UNITS;
      end
   end

   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      fe_in         = fe_ff;
      bit_cnt_in    = bit_cnt_ff;
      run_bit_in    = run_bit_ff;
      hund_in       = hund_ff;
      tens_in       = tens_ff;
      units_in      = units_ff;
      em_hund_in    = em_hund_ff;
      em_tens_in    = em_tens_ff;
      em_units_in   = em_units_ff;
      em_bit_in     = em_bit_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_rbit_in  = pend_rbit_ff;
      byte_res_in   = byte_res_ff;
      q_pop         = 1'b0;
      push          = 1'b0;
      cur_sym       = em_units_ff;
      cur_rbit      = 1'b0;
      push_data.symbol_nibble = pend_sym_ff;
      push_data.is_run_bit    = pend_rbit_ff;
      push_data.last          = 1'b0;
      push_data.frame_done    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               byte_in    = q_head.data_byte;
               fe_in      = q_head.frame_end;
               bit_cnt_in = '0;
               state_in   = ST_BITS;
            end
         end
         ST_BITS: begin
            byte_in    = {byte_ff[6:0], 1'b0};
            bit_cnt_in = bre_pkg::BCNT_W'(bit_cnt_ff + 1'b1);
            run_bit_in = bit_now;
            if (count_nz && (bit_now != run_bit_ff)) begin
               em_hund_in  = hund_ff;
               em_tens_in  = tens_ff;
               em_units_in = units_ff;
               em_bit_in   = run_bit_ff;
               hund_in     = '0;
               tens_in     = '0;
               units_in    = 4'd1;
               state_in    = first_digit;
            end else begin
               if (units_ff == 4'd9) begin
                  units_in = '0;
                  if (tens_ff == 4'd9) begin
                     tens_in = '0;
                     hund_in = hund_ff + 4'd1;
                  end else begin
                     tens_in = tens_ff + 4'd1;
                  end
               end else begin
                  units_in = units_ff + 4'd1;
               end
               if (bit_cnt_ff == bre_pkg::BCNT_W'(bre_pkg::BITS_PER_BYTE - 1)) begin
                  state_in = ST_END;
               end
            end
         end
         ST_HUND, ST_TENS, ST_UNITS, ST_RBIT: begin
            if (state_ff == ST_HUND) begin
               cur_sym = em_hund_ff;
            end else if (state_ff == ST_TENS) begin
               cur_sym = em_tens_ff;
            end else if (state_ff == ST_RBIT) begin
               cur_sym  = {3'b000, em_bit_ff};
               cur_rbit = 1'b1;
            end
            if (!(room && pend_valid_ff && !out_free)) begin
               if (room) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_sym_in   = cur_sym;
                  pend_rbit_in  = cur_rbit;
                  byte_res_in   = bre_pkg::RES_W'(byte_res_ff + 1'b1);
               end
               if (state_ff == ST_HUND) begin
                  state_in = ST_TENS;
               end else if (state_ff == ST_TENS) begin
                  state_in = ST_UNITS;
               end else if (state_ff == ST_UNITS) begin
                  state_in = ST_RBIT;
               end else if (bit_cnt_ff == bre_pkg::BCNT_W'(bre_pkg::BITS_PER_BYTE)) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_BITS;
               end
            end
         end
         ST_END: begin
            if (fe_ff && count_nz) begin
               em_hund_in  = hund_ff;
               em_tens_in  = tens_ff;
               em_units_in = units_ff;
               em_bit_in   = run_bit_ff;
               hund_in     = '0;
               tens_in     = '0;
               units_in    = '0;
               run_bit_in  = 1'b0;
               state_in    = first_digit;
            end else if (!(pend_valid_ff && !out_free)) begin
               push                 = pend_valid_ff;
               push_data.last       = 1'b1;
               push_data.frame_done = fe_ff;
               pend_valid_in        = 1'b0;
               byte_res_in          = '0;
               if (q_valid) begin
                  q_pop      = 1'b1;
                  byte_in    = q_head.data_byte;
                  fe_in      = q_head.frame_end;
                  bit_cnt_in = '0;
                  state_in   = ST_BITS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_in       = push_data;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_cnt_ff    <= '0;
         run_bit_ff    <= 1'b0;
         hund_ff       <= '0;
         tens_ff       <= '0;
         units_ff      <= '0;
         pend_valid_ff <= 1'b0;
         byte_res_ff   <= '0;
         out_valid_ff  <= 1'b0;
         fe_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_cnt_ff    <= bit_cnt_in;
         run_bit_ff    <= run_bit_in;
         hund_ff       <= hund_in;
         tens_ff       <= tens_in;
         units_ff      <= units_in;
         pend_valid_ff <= pend_valid_in;
         byte_res_ff   <= byte_res_in;
         out_valid_ff  <= out_valid_in;
         fe_ff         <= fe_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      em_hund_ff  <= em_hund_in;
      em_tens_ff  <= em_tens_in;
      em_units_ff <= em_units_in;
      em_bit_ff   <= em_bit_in;
      pend_sym_ff <= pend_sym_in;
      pend_rbit_ff <= pend_rbit_in;
      out_ff      <= out_in;
   end

   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      byte_res_ff <= bre_pkg::RES_W'(bre_pkg::MAX_RESULTS))
      else $error("Result count of one byte exceeds its limit.");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("A held result is left behind with no byte in progress.");

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      (hund_ff <= 4'd9) && (tens_ff <= 4'd9) && (units_ff <= 4'd9))
      else $error("Run counter holds a digit above nine.");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_done) |-> out_ff.last)
      else $error("Frame end marked on an item that does not close its byte.");

   a_push_clears_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && state_in != ST_END && fe_ff && !count_nz) |=> !count_nz)
      else $error("Run state not cleared at the end of a frame.");

endmodule

/* rtl/core/bit_run_length_encoder.sv */
// Top level of the bit run-length encoder.
//
//   Channel   Dir  Payload                                       Handshake
//   req_ch    in   data_byte[7:0]                                valid/ready
//   rsp_ch    out  symbol_nibble[3:0] is_run_bit last frame_done valid/ready
//
// The back end walks the eight bits of a byte one bit a cycle, pausing to hand out
// the nibbles of each run it closes, and ends the byte in a closing state that also loads the next byte.
// A byte that finds the back end idle is first loaded from the idle state. Each nibble of a
// closed run takes its own state, dropped ones included, and the last byte of a frame
// passes through the nibble states once more to close its final run.
// A two-entry queue lets the front accept bytes while the back is busy.
// Reset is synchronous and returns the frame position and open run to zero.
// A stalled response holds the back end only when it has a result to hand over.
module bit_run_length_encoder (
   input logic     clock,
   input logic     reset,
   bre_req_if.sink   req_ch,
   bre_rsp_if.source rsp_ch
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_not_empty;
   bre_pkg::entry_type  q_entry;
   bre_pkg::entry_type  q_head;
   bre_pkg::result_type rsp_data;
   logic                rsp_valid;

   bre_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_byte  (req_ch.data_byte),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   bre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   bre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.symbol_nibble = rsp_data.symbol_nibble;
   assign rsp_ch.is_run_bit    = rsp_data.is_run_bit;
   assign rsp_ch.last          = rsp_data.last;
   assign rsp_ch.frame_done    = rsp_data.frame_done;

endmodule

/* sim/bre_stream_checker.sv */
`timescale 1ns / 1ps
// Predicts the encoder's nibble stream from accepted bytes and checks every accepted result.
module bre_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [3:0] rsp_symbol_nibble,
   input  logic       rsp_is_run_bit,
   input  logic       rsp_last,
   input  logic       rsp_frame_done,
   output int         mismatch_count,
   output int         nibbles_due_count
);

   bre_pkg::result_type nibbles_due[$];
   bre_pkg::result_type byte_nibbles[$];
   logic       open_bit;
   logic [9:0] open_len;
   logic [6:0] frame_pos;
   int         errors = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
      end
   endtask

   function automatic void close_run(input logic [9:0] len, input logic run_value);
      int                  div;
      int                  digit;
      bit                  started;
      bre_pkg::result_type r;
      started = 1'b0;
      for (div = 1000; div != 0; div = div / 10) begin
         digit = (int'(len) / div) % 10;
         if (digit != 0 || started || div == 1) begin
            r = '0;
            r.symbol_nibble = digit[3:0];
            byte_nibbles.push_back(r);
            started = 1'b1;
         end
      end
      r = '0;
      r.symbol_nibble = {3'b000, run_value};
      r.is_run_bit = 1'b1;
      byte_nibbles.push_back(r);
   endfunction

   task automatic encode_byte(input logic [7:0] data);
      logic                frame_end;
      int                  n;
      bre_pkg::result_type r;
      byte_nibbles.delete();
      frame_end = 1'b0;
      for (int k = 7; k >= 0; k--) begin
         if (open_len != 10'd0 && data[k] != open_bit) begin
            close_run(open_len, open_bit);
            open_len = 10'd0;
         end
         open_bit = data[k];
         if (open_len < 10'd1023) begin
            open_len = open_len + 10'd1;
         end
      end
      frame_pos = frame_pos + 7'd1;
      if (frame_pos >= bre_pkg::FRAME_BYTES) begin
         if (open_len != 10'd0) begin
            close_run(open_len, open_bit);
         end
         frame_end = 1'b1;
         open_bit = 1'b0;
         open_len = 10'd0;
         frame_pos = 7'd0;
      end
      // Nibbles past the per-byte limit are lost; the last one kept closes the byte.
      n = (byte_nibbles.size() > bre_pkg::MAX_RESULTS) ? bre_pkg::MAX_RESULTS
                                                        : byte_nibbles.size();
      for (int k = 0; k < n; k++) begin
         r = byte_nibbles[k];
         r.last = (k == n - 1);
         r.frame_done = (k == n - 1) && frame_end;
         nibbles_due.push_back(r);
      end
   endtask

   always @(posedge clock) begin : watch
      bre_pkg::result_type want;
      if (reset) begin
         open_bit = 1'b0;
         open_len = 10'd0;
         frame_pos = 7'd0;
         nibbles_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (nibbles_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result, nibble %0d", rsp_symbol_nibble));
            end else begin
               want = nibbles_due.pop_front();
               compare_field("symbol_nibble", rsp_symbol_nibble, want.symbol_nibble);
               compare_field("is_run_bit", rsp_is_run_bit, want.is_run_bit);
               compare_field("last", rsp_last, want.last);
               compare_field("frame_done", rsp_frame_done, want.frame_done);
            end
         end
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte);
         end
      end
      mismatch_count <= errors;
      nibbles_due_count <= nibbles_due.size();
   end

endmodule

/* sim/bit_run_length_encoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the bit run-length encoder: clock, reset, byte frames and result pacing.
module bit_run_length_encoder_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 104;
   localparam int HOLD_AFTER   = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 60;

   localparam logic [7:0] OPENING [24] = '{
      8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h80, 8'h01,
      8'h7F, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum int {
      FILL_RANDOM,
      FILL_SPARSE,
      FILL_OVERFLOW
   } fill_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   sent = 0;
   int   taken = 0;
   int   mismatches;
   int   due;
   bit   send_burst = 1'b0;
   bit   take_burst = 1'b0;

   bre_req_if req_ch ();
   bre_rsp_if rsp_ch ();

   bit_run_length_encoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bre_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_data_byte     (req_ch.data_byte),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_symbol_nibble (rsp_ch.symbol_nibble),
      .rsp_is_run_bit    (rsp_ch.is_run_bit),
      .rsp_last          (rsp_ch.last),
      .rsp_frame_done    (rsp_ch.frame_done),
      .mismatch_count    (mismatches),
      .nibbles_due_count (due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("bit_run_length_encoder_tb: FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] next_byte(input fill_mode_type mode, input logic [7:0] base,
                                            input int pos);
      unique case (mode)
         FILL_SPARSE: begin
            return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : base;
         end
         FILL_OVERFLOW: begin
            // A long run broken at the first bit of the last byte, then alternating bits.
            return (pos < bre_pkg::FRAME_BYTES - 1) ? base : (base ^ 8'hAA);
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] data);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= data;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (due != 0);
   endtask

   initial begin : take_side
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 20 == 0) begin
            take_burst = ($urandom_range(0, 3) == 0);
         end
         stall = take_burst ? 0 : $urandom_range(0, 15);
         if (taken == HOLD_AFTER) begin
            stall = HOLD_CYCLES;
         end
         repeat (stall) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
      end
   end

   initial begin : drive_side
      fill_mode_type mode;
      logic [7:0]    base;
      mode = FILL_RANDOM;
      base = 8'h00;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i]) begin
         send_byte(OPENING[i]);
      end
      wait_drained();
      repeat (RANDOM_BYTES) begin
         if (sent % bre_pkg::FRAME_BYTES == 0) begin
            mode = (sent / bre_pkg::FRAME_BYTES == 1) ? FILL_OVERFLOW
                                                      : fill_mode_type'($urandom_range(0, 2));
            base = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            send_burst = ($urandom_range(0, 3) == 0);
         end
         send_byte(next_byte(mode, base, sent % bre_pkg::FRAME_BYTES));
      end
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && due == 0) begin
         $display("bit_run_length_encoder_tb: PASS");
      end else begin
         $display("bit_run_length_encoder_tb: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/bre_pkg.sv
rtl/core/bre_if.sv
rtl/core/bre_front.sv
rtl/core/bre_queue.sv
rtl/core/bre_back.sv
rtl/core/bit_run_length_encoder.sv
sim/bre_stream_checker.sv
sim/bit_run_length_encoder_tb.sv
